>>> hdl/tlnsf_pkg.sv
`default_nettype none

package tlnsf_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_ALL       = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CTRL_MAX     = 8'h1F;
    localparam logic [7:0] HIGH_MIN     = 8'h80;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    localparam logic [3:0] BCD_NINE = 4'd9;

endpackage

`default_nettype wire

>>> hdl/text_line_number_and_show_filter_top.sv
// timing: the first result byte is registered on acceptance and shown in the next cycle
// throughput: an item with n result bytes holds the burst register until its last byte
//   is taken; the next item is taken in that cycle; a squeezed line gives no bytes
// burst register and index set the rate: one output byte per cycle, stalled by m_ready low
// reset: synchronous active-low aresetn clears the config, valid and index registers and
//   the line state, sets the line counter to one; burst data stays; no clearing pass
`default_nettype none

module text_line_number_and_show_filter_top #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tlnsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_data_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_last_of_run
);
    import tlnsf_pkg::*;

    localparam int CNT_BITS = 4 * NUMBER_DIGITS;
    localparam int MAX_RES  = NUMBER_DIGITS + 3;
    localparam int IDX_W    = $clog2(MAX_RES);
    localparam int CNT_W    = $clog2(MAX_RES + 1);
    localparam logic [CNT_W-1:0] NUM_LEN = CNT_W'(NUMBER_DIGITS + 1);

    cfg_t cfg_reg;

    logic                line_start_reg, line_start_next;
    logic [1:0]          empty_run_reg, empty_run_next;
    logic [CNT_BITS-1:0] counter_reg, counter_next;

    logic [7:0]          burst_reg [MAX_RES];
    logic [7:0]          burst_next [MAX_RES];
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    idx_reg;
    logic                valid_reg;

    logic accept;
    logic drop;
    logic last_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_wr_data;
                REG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_wr_data;
                REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_wr_data;
                REG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_wr_data;
                REG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_wr_data;
                REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign last_out = (CNT_W'(idx_reg) + CNT_W'(1)) == len_reg;
    assign s_ready  = !valid_reg || (m_ready && last_out);
    assign accept   = s_valid && s_ready;

    always_comb begin
        logic                is_nl;
        logic                numbered;
        logic                full;
        logic                carry;
        logic                seen;
        logic [3:0]          d;
        logic [7:0]          num_byte [NUMBER_DIGITS];
        logic [7:0]          c0, c1;
        logic [CNT_W-1:0]    off;
        logic                two;

        is_nl = (s_data_byte == CH_NL);

        empty_run_next = empty_run_reg;
        if (line_start_reg) begin
            if (is_nl) begin
                empty_run_next = (empty_run_reg < 2'd2) ? empty_run_reg + 2'd1 : empty_run_reg;
            end else begin
                empty_run_next = 2'd0;
            end
        end
        drop = line_start_reg && cfg_reg.squeeze_blank && (empty_run_next > 2'd1);

        numbered = line_start_reg && !drop &&
                   (cfg_reg.number_all || (cfg_reg.number_nonblank && !is_nl));

        // leading zeros shown as blanks, the lowest digit always shown
        seen = 1'b0;
        for (int p = NUMBER_DIGITS - 1; p >= 0; p--) begin
            d = counter_reg[4*p +: 4];
            if (d != 4'd0 || p == 0) seen = 1'b1;
            num_byte[NUMBER_DIGITS-1-p] = seen ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
        end

        full = 1'b1;
        for (int p = 0; p < NUMBER_DIGITS; p++) begin
            if (counter_reg[4*p +: 4] != BCD_NINE) full = 1'b0;
        end
        counter_next = counter_reg;
        carry = 1'b1;
        for (int p = 0; p < NUMBER_DIGITS; p++) begin
            d = counter_reg[4*p +: 4];
            if (carry) begin
                if (d >= BCD_NINE) begin
                    counter_next[4*p +: 4] = 4'd0;
                end else begin
                    counter_next[4*p +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (full || !numbered) counter_next = counter_reg;

        c0  = s_data_byte;
        c1  = s_data_byte;
        two = 1'b0;
        if (cfg_reg.show_tabs && s_data_byte == CH_TAB) begin
            c0  = CH_CARET;
            c1  = CH_I;
            two = 1'b1;
        end else if (cfg_reg.show_ends && is_nl) begin
            c0  = CH_DOLLAR;
            two = 1'b1;
        end else if (cfg_reg.show_nonprinting && !is_nl && s_data_byte != CH_TAB) begin
            if (s_data_byte <= CTRL_MAX || s_data_byte >= HIGH_MIN) begin
                c0  = CH_CARET;
                c1  = s_data_byte + CARET_OFFSET;
                two = 1'b1;
            end else if (s_data_byte == CH_DEL) begin
                c0  = CH_CARET;
                c1  = CH_QMARK;
                two = 1'b1;
            end
        end

        off      = numbered ? NUM_LEN : CNT_W'(0);
        len_next = off + (two ? CNT_W'(2) : CNT_W'(1));
        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_W'(i) < off) begin
                burst_next[i] = (i < NUMBER_DIGITS) ? num_byte[i % NUMBER_DIGITS] : CH_TAB;
            end else if (CNT_W'(i) == off) begin
                burst_next[i] = c0;
            end else begin
                burst_next[i] = c1;
            end
        end

        line_start_next = drop ? line_start_reg : is_nl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_start_reg <= 1'b1;
            empty_run_reg  <= 2'd0;
            counter_reg    <= CNT_BITS'(1);
        end else if (accept) begin
            line_start_reg <= line_start_next;
            empty_run_reg  <= empty_run_next;
            counter_reg    <= counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (accept && !drop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (last_out) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !drop) begin
            burst_reg <= burst_next;
            len_reg   <= len_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = burst_reg[idx_reg];
    assign m_last_of_run = last_out;

endmodule

`default_nettype wire

>>> hdl/tlnsf_checker.sv
`default_nettype none

module tlnsf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last_of_run
);

    // stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_of_run))
        else $error("stalled result item changed");

    // no new input item while a burst is mid-way
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input ready in the middle of a burst");

    // burst drained and nothing taken leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run && !(s_valid && s_ready) |=> !m_valid)
        else $error("result shown without an input item");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty after reset");

endmodule

bind text_line_number_and_show_filter_top tlnsf_checker u_tlnsf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_last_of_run (m_last_of_run)
);

`default_nettype wire
